### rtl/core/relay_frame_parser_assert.svh
// Assertion macros of the relay frame parser checker.
`ifndef RELAY_FRAME_PARSER_ASSERT_SVH
`define RELAY_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RFP_CHECK(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("relay frame parser check failed");

// next-cycle implication
`define RFP_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("relay frame parser check failed");

`endif

### rtl/core/rfp_pkg.sv
// Types and constants of the relay frame parser.
package rfp_pkg;

	localparam int unsigned PAYLOAD_LIMIT = 16 * 1024 * 1024;

	typedef enum logic [1:0] {
		REG_FRAME_VERSION = 2'd0,
		REG_MAX_TYPE      = 2'd1,
		REG_MAX_STATUS    = 2'd2,
		REG_MAX_PAYLOAD   = 2'd3
	} reg_index_t;

	typedef enum logic [3:0] {
		PH_VERSION    = 4'd0,
		PH_TYPE       = 4'd1,
		PH_STATUS     = 4'd2,
		PH_LEN_A      = 4'd3,
		PH_STR_A      = 4'd4,
		PH_LEN_B      = 4'd5,
		PH_STR_B      = 4'd6,
		PH_LEN_C      = 4'd7,
		PH_STR_C      = 4'd8,
		PH_ID         = 4'd9,
		PH_EXPIRY     = 4'd10,
		PH_DURATION   = 4'd11,
		PH_DATA_LIMIT = 4'd12,
		PH_PAY_LEN    = 4'd13,
		PH_PAYLOAD    = 4'd14,
		PH_IGNORE     = 4'd15
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_VERSION = 3'd1,
		ST_BAD_TYPE    = 3'd2,
		ST_BAD_LENGTH  = 3'd3,
		ST_TRUNCATED   = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0]  frame_version;
		logic [7:0]  max_type;
		logic [7:0]  max_status;
		logic [24:0] max_payload;
	} cfg_t;

	typedef struct packed {
		logic [3:0]         field_kind;
		logic [23:0]        byte_offset;
		logic [7:0]         byte_out;
		logic signed [63:0] field_value;
		logic               value_valid;
		logic               frame_end;
		logic [2:0]         frame_status;
	} res_t;

endpackage

### rtl/core/rfp_feed_if.sv
// Input channel: one frame byte per word.
interface rfp_feed_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

### rtl/core/rfp_result_if.sv
// Result channel: field annotation of one frame byte per word.
interface rfp_result_if;
	logic               valid;
	logic               ready;
	logic [3:0]         field_kind;
	logic [23:0]        byte_offset;
	logic [7:0]         byte_out;
	logic signed [63:0] field_value;
	logic               value_valid;
	logic               frame_end;
	logic [2:0]         frame_status;

	modport source (output valid, output field_kind, output byte_offset, output byte_out,
		output field_value, output value_valid, output frame_end, output frame_status,
		input ready);
	modport sink (input valid, input field_kind, input byte_offset, input byte_out,
		input field_value, input value_valid, input frame_end, input frame_status,
		output ready);
endinterface

### rtl/core/rfp_cfg_regs.sv
// Configuration registers of the relay frame parser.
module rfp_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [24:0]   cfg_data,
	output rfp_pkg::cfg_t cfg
);

	rfp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_version <= 8'd1;
			cfg_q.max_type      <= 8'd5;
			cfg_q.max_status    <= 8'd8;
			cfg_q.max_payload   <= 25'(rfp_pkg::PAYLOAD_LIMIT);
		end else if (cfg_we) begin
			unique case (rfp_pkg::reg_index_t'(cfg_index))
				rfp_pkg::REG_FRAME_VERSION: cfg_q.frame_version <= cfg_data[7:0];
				rfp_pkg::REG_MAX_TYPE:      cfg_q.max_type      <= cfg_data[7:0];
				rfp_pkg::REG_MAX_STATUS:    cfg_q.max_status    <= cfg_data[7:0];
				rfp_pkg::REG_MAX_PAYLOAD:   cfg_q.max_payload   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/rfp_tracker.sv
// Frame layout tracker: field state, value assembly and checks for one byte.
module rfp_tracker #(
	parameter int CONN_ID_BYTES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    data_byte,
	input  logic          last,
	input  rfp_pkg::cfg_t cfg,
	output rfp_pkg::res_t res
);

	localparam logic [23:0] ID_LAST = 24'(CONN_ID_BYTES - 1);

	rfp_pkg::phase_t  phase_q, phase_n, phase_d;
	rfp_pkg::status_t err_q, err_n, err_d;
	logic [23:0] off_q, off_d, off_inc;
	logic [24:0] flen_q, flen_d;
	logic [63:0] acc_q, acc_d, acc_new;
	logic [7:0]  type_q, type_d;
	logic        num_done, enter;
	logic [31:0] raw_len;

	assign acc_new = acc_q | ({56'd0, data_byte} << {off_q[2:0], 3'b000});
	assign off_inc = off_q + 24'd1;
	assign raw_len = acc_new[31:0];

	always_comb begin
		case (phase_q)
			rfp_pkg::PH_LEN_A, rfp_pkg::PH_LEN_B, rfp_pkg::PH_LEN_C:
				num_done = (off_q[2:0] == 3'd1);
			rfp_pkg::PH_DURATION, rfp_pkg::PH_PAY_LEN:
				num_done = (off_q[2:0] == 3'd3);
			rfp_pkg::PH_EXPIRY, rfp_pkg::PH_DATA_LIMIT:
				num_done = (off_q[2:0] == 3'd7);
			default:
				num_done = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		phase_n = phase_q;
		err_n   = err_q;
		flen_d  = flen_q;
		type_d  = type_q;
		off_d   = off_q;
		acc_d   = acc_q;
		enter   = 1'b0;
		unique case (phase_q)
			rfp_pkg::PH_VERSION: begin
				enter = 1'b1;
				if (data_byte != cfg.frame_version) begin
					err_n   = rfp_pkg::ST_BAD_VERSION;
					phase_n = rfp_pkg::PH_IGNORE;
				end else begin
					phase_n = rfp_pkg::PH_TYPE;
				end
			end
			rfp_pkg::PH_TYPE: begin
				enter   = 1'b1;
				type_d  = data_byte;
				phase_n = rfp_pkg::PH_STATUS;
			end
			rfp_pkg::PH_STATUS: begin
				enter = 1'b1;
				if (type_q == 8'd0 || type_q > cfg.max_type || data_byte > cfg.max_status) begin
					err_n   = rfp_pkg::ST_BAD_TYPE;
					phase_n = rfp_pkg::PH_IGNORE;
				end else begin
					phase_n = rfp_pkg::PH_LEN_A;
				end
			end
			rfp_pkg::PH_LEN_A, rfp_pkg::PH_LEN_B, rfp_pkg::PH_LEN_C: begin
				if (num_done) begin
					enter  = 1'b1;
					flen_d = {9'd0, acc_new[15:0]};
					if (acc_new[15:0] != 16'd0) begin
						phase_n = rfp_pkg::phase_t'(phase_q + 4'd1);
					end else begin
						phase_n = rfp_pkg::phase_t'(phase_q + 4'd2);
					end
				end else begin
					off_d = off_inc;
					acc_d = acc_new;
				end
			end
			rfp_pkg::PH_EXPIRY, rfp_pkg::PH_DURATION, rfp_pkg::PH_DATA_LIMIT: begin
				if (num_done) begin
					enter   = 1'b1;
					phase_n = rfp_pkg::phase_t'(phase_q + 4'd1);
				end else begin
					off_d = off_inc;
					acc_d = acc_new;
				end
			end
			rfp_pkg::PH_PAY_LEN: begin
				if (num_done) begin
					enter = 1'b1;
					if (raw_len[31] || raw_len > {7'd0, cfg.max_payload}) begin
						err_n   = rfp_pkg::ST_BAD_LENGTH;
						phase_n = rfp_pkg::PH_IGNORE;
					end else if (raw_len == 32'd0) begin
						phase_n = rfp_pkg::PH_IGNORE;
					end else begin
						flen_d  = raw_len[24:0];
						phase_n = rfp_pkg::PH_PAYLOAD;
					end
				end else begin
					off_d = off_inc;
					acc_d = acc_new;
				end
			end
			rfp_pkg::PH_STR_A, rfp_pkg::PH_STR_B, rfp_pkg::PH_STR_C, rfp_pkg::PH_PAYLOAD: begin
				off_d = off_inc;
				if (flen_q != 25'd0) begin
					flen_d = flen_q - 25'd1;
				end
				if (flen_q <= 25'd1) begin
					enter = 1'b1;
					if (phase_q == rfp_pkg::PH_PAYLOAD) begin
						phase_n = rfp_pkg::PH_IGNORE;
					end else begin
						phase_n = rfp_pkg::phase_t'(phase_q + 4'd1);
					end
				end
			end
			rfp_pkg::PH_ID: begin
				if (off_q == ID_LAST) begin
					enter   = 1'b1;
					phase_n = rfp_pkg::PH_EXPIRY;
				end else begin
					off_d = off_inc;
				end
			end
			rfp_pkg::PH_IGNORE: ;
			default: ;
		endcase
		if (enter) begin
			off_d = 24'd0;
			acc_d = 64'd0;
		end
		phase_d = phase_n;
		err_d   = err_n;
		if (last) begin
			phase_d = rfp_pkg::PH_VERSION;
			err_d   = rfp_pkg::ST_OK;
			off_d   = 24'd0;
			flen_d  = 25'd0;
			acc_d   = 64'd0;
			type_d  = 8'd0;
		end
	end

	// result word
	always_comb begin
		res.field_kind  = phase_q;
		res.byte_offset = (phase_q == rfp_pkg::PH_IGNORE) ? 24'd0 : off_q;
		res.byte_out    = data_byte;
		res.value_valid = num_done;
		res.field_value = 64'sd0;
		if (num_done) begin
			case (phase_q)
				rfp_pkg::PH_LEN_A, rfp_pkg::PH_LEN_B, rfp_pkg::PH_LEN_C:
					res.field_value = {48'd0, acc_new[15:0]};
				rfp_pkg::PH_DURATION, rfp_pkg::PH_PAY_LEN:
					res.field_value = {{32{acc_new[31]}}, acc_new[31:0]};
				default:
					res.field_value = acc_new;
			endcase
		end
		res.frame_end    = last;
		res.frame_status = rfp_pkg::ST_OK;
		if (last) begin
			if (err_n != rfp_pkg::ST_OK) begin
				res.frame_status = err_n;
			end else if (phase_n != rfp_pkg::PH_IGNORE) begin
				res.frame_status = rfp_pkg::ST_TRUNCATED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rfp_pkg::PH_VERSION;
			err_q   <= rfp_pkg::ST_OK;
			off_q   <= 24'd0;
			flen_q  <= 25'd0;
			acc_q   <= 64'd0;
			type_q  <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			err_q   <= err_d;
			off_q   <= off_d;
			flen_q  <= flen_d;
			acc_q   <= acc_d;
			type_q  <= type_d;
		end
	end

endmodule

### rtl/core/relay_frame_parser.sv
// Top level of the relay frame parser.
// Usage:
//   feed carries one raw frame byte per word, with last set on the buffer's
//   final byte. result returns one word per accepted byte, in order: the
//   field kind, the offset within the field, the byte, the little-endian
//   value when a length or numeric field completes, and on the final byte
//   the frame verdict in frame_status.
//   An accepted byte is taken into the input register, which feeds the
//   layout tracker; the tracker's word lands in the result register.
//   Throughput is one byte per cycle while result is not stalled; the
//   tracker updates its state as each word moves from the input register
//   into the result register.
//   While result is stalled, one more byte is taken into the input register;
//   after that feed.ready drops until the result word is taken.
//   Reset empties both registers, restores the register defaults and puts
//   the tracker at the start of a frame. The byte after a final byte opens
//   a new frame. cfg_we writes register cfg_index with cfg_data; write only
//   while no byte is in flight.
module relay_frame_parser #(
	parameter int CONN_ID_BYTES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	rfp_feed_if.sink       feed,
	rfp_result_if.source   result,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [24:0]    cfg_data
);

	rfp_pkg::cfg_t cfg;
	rfp_pkg::res_t res_c, res_s2;
	logic       valid_s1, valid_s2;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign feed.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (feed.ready) begin
				valid_s1 <= feed.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (feed.valid && feed.ready) begin
			byte_s1 <= feed.data_byte;
			last_s1 <= feed.last;
		end
		if (advance) begin
			res_s2 <= res_c;
		end
	end

	rfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rfp_tracker #(
		.CONN_ID_BYTES (CONN_ID_BYTES)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.last      (last_s1),
		.cfg       (cfg),
		.res       (res_c)
	);

	assign result.valid        = valid_s2;
	assign result.field_kind   = res_s2.field_kind;
	assign result.byte_offset  = res_s2.byte_offset;
	assign result.byte_out     = res_s2.byte_out;
	assign result.field_value  = res_s2.field_value;
	assign result.value_valid  = res_s2.value_valid;
	assign result.frame_end    = res_s2.frame_end;
	assign result.frame_status = res_s2.frame_status;

endmodule

### rtl/core/rfp_checker.sv
// Port-level checker of the relay frame parser, with its bind.
`include "relay_frame_parser_assert.svh"

module rfp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic [3:0]         field_kind,
	input logic [23:0]        byte_offset,
	input logic signed [63:0] field_value,
	input logic               value_valid,
	input logic               frame_end,
	input logic [2:0]         frame_status
);

	`RFP_CHECK_NEXT(a_result_held, res_valid && !res_ready, res_valid)
	`RFP_CHECK(a_status_on_end, res_valid && frame_status != rfp_pkg::ST_OK, frame_end)
	`RFP_CHECK(a_value_zero, res_valid && !value_valid, field_value == 64'sd0)
	`RFP_CHECK(a_ignored_offset, res_valid && field_kind == rfp_pkg::PH_IGNORE, byte_offset == 24'd0)

endmodule

bind relay_frame_parser rfp_checker u_rfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.field_kind   (result.field_kind),
	.byte_offset  (result.byte_offset),
	.field_value  (result.field_value),
	.value_valid  (result.value_valid),
	.frame_end    (result.frame_end),
	.frame_status (result.frame_status)
);

### verif/relay_frame_parser_test.sv
// Self-checking testbench of the relay frame parser: random frames, stalls and config phases.
`timescale 1ns / 1ps

module relay_frame_parser_test;
	import rfp_pkg::*;

	localparam int CONN_ID_BYTES = 16;
	localparam int DRAIN_CYCLES = 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int BYTES_PER_PHASE = 370;

	class frame_scoreboard;
		cfg_t cfg;
		phase_t phase;
		logic [23:0] offset;
		logic [24:0] field_len;
		logic [63:0] assembled;
		logic [7:0] held_type;
		status_t err;
		res_t expected_words[$];
		int unsigned mismatch_count;

		function new();
			cfg = '{frame_version: 8'd1, max_type: 8'd5, max_status: 8'd8,
				max_payload: 25'(PAYLOAD_LIMIT)};
			mismatch_count = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			phase = PH_VERSION;
			offset = '0;
			field_len = '0;
			assembled = '0;
			held_type = '0;
			err = ST_OK;
		endfunction

		function void enter(phase_t next);
			phase = next;
			offset = '0;
			assembled = '0;
		endfunction

		function void write_reg(reg_index_t idx, logic [24:0] data);
			case (idx)
				REG_FRAME_VERSION: cfg.frame_version = data[7:0];
				REG_MAX_TYPE: cfg.max_type = data[7:0];
				REG_MAX_STATUS: cfg.max_status = data[7:0];
				REG_MAX_PAYLOAD: cfg.max_payload = data;
			endcase
		endfunction

		function int unsigned number_width(phase_t ph);
			case (ph)
				PH_LEN_A, PH_LEN_B, PH_LEN_C: return 2;
				PH_EXPIRY, PH_DATA_LIMIT: return 8;
				PH_DURATION, PH_PAY_LEN: return 4;
				default: return 0;
			endcase
		endfunction

		// advance the frame layout by one byte and queue the annotated word
		function void note_byte(logic [7:0] b, logic l);
			res_t r;
			int unsigned size;
			logic [63:0] val;
			logic [31:0] raw;
			r = '0;
			r.field_kind = phase;
			r.byte_offset = offset;
			r.byte_out = b;
			r.frame_end = l;
			size = number_width(phase);
			if (size != 0) begin
				assembled = assembled | (64'(b) << (8 * offset[2:0]));
				offset = offset + 24'd1;
				if (offset >= size) begin
					val = assembled;
					if (size == 4)
						val = {{32{assembled[31]}}, assembled[31:0]};
					r.value_valid = 1'b1;
					r.field_value = val;
					case (phase)
						PH_LEN_A, PH_LEN_B, PH_LEN_C: begin
							field_len = 25'(val[15:0]);
							enter(field_len != 0 ? phase_t'(phase + 1) : phase_t'(phase + 2));
						end
						PH_PAY_LEN: begin
							raw = assembled[31:0];
							if (raw[31] || raw > 32'(cfg.max_payload)) begin
								err = ST_BAD_LENGTH;
								enter(PH_IGNORE);
							end else if (raw == 0) begin
								enter(PH_IGNORE);
							end else begin
								field_len = raw[24:0];
								enter(PH_PAYLOAD);
							end
						end
						default: enter(phase_t'(phase + 1));
					endcase
				end
			end else begin
				case (phase)
					PH_VERSION: begin
						if (b != cfg.frame_version) begin
							err = ST_BAD_VERSION;
							enter(PH_IGNORE);
						end else begin
							enter(PH_TYPE);
						end
					end
					PH_TYPE: begin
						held_type = b;
						enter(PH_STATUS);
					end
					PH_STATUS: begin
						if (held_type == 0 || held_type > cfg.max_type || b > cfg.max_status) begin
							err = ST_BAD_TYPE;
							enter(PH_IGNORE);
						end else begin
							enter(PH_LEN_A);
						end
					end
					PH_STR_A, PH_STR_B, PH_STR_C, PH_PAYLOAD: begin
						offset = offset + 24'd1;
						if (field_len != 0)
							field_len = field_len - 25'd1;
						if (field_len == 0)
							enter(phase == PH_PAYLOAD ? PH_IGNORE : phase_t'(phase + 1));
					end
					PH_ID: begin
						offset = offset + 24'd1;
						if (offset >= CONN_ID_BYTES)
							enter(PH_EXPIRY);
					end
					default: begin
						r.field_kind = PH_IGNORE;
						r.byte_offset = '0;
						phase = PH_IGNORE;
					end
				endcase
			end
			if (l) begin
				if (err != ST_OK)
					r.frame_status = err;
				else if (phase == PH_IGNORE)
					r.frame_status = ST_OK;
				else
					r.frame_status = ST_TRUNCATED;
				clear_frame();
			end
			expected_words.push_back(r);
		endfunction

		function void check_word(res_t got);
			res_t want;
			if (expected_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result word: %p", got);
				return;
			end
			want = expected_words.pop_front();
			if (got.field_kind !== want.field_kind || got.byte_offset !== want.byte_offset ||
					got.byte_out !== want.byte_out || got.field_value !== want.field_value ||
					got.value_valid !== want.value_valid || got.frame_end !== want.frame_end ||
					got.frame_status !== want.frame_status) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("mismatch exp: kind %0d off %0d byte %h val %h vv %b end %b st %0d",
						want.field_kind, want.byte_offset, want.byte_out, want.field_value,
						want.value_valid, want.frame_end, want.frame_status);
					$display("         got: kind %0d off %0d byte %h val %h vv %b end %b st %0d",
						got.field_kind, got.byte_offset, got.byte_out, got.field_value,
						got.value_valid, got.frame_end, got.frame_status);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	reg_index_t cfg_index;
	logic [24:0] cfg_data;

	rfp_feed_if feed();
	rfp_result_if result();

	relay_frame_parser #(.CONN_ID_BYTES(CONN_ID_BYTES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.feed(feed),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	frame_scoreboard sb = new();
	logic [7:0] frame_bytes[$];
	res_t seen_word;
	int unsigned bytes_sent = 0;
	int unsigned burst_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned recv_cycle = 0;
	int unsigned recv_mode = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && feed.valid && feed.ready)
			sb.note_byte(feed.data_byte, feed.last);
	end

	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			seen_word.field_kind = result.field_kind;
			seen_word.byte_offset = result.byte_offset;
			seen_word.byte_out = result.byte_out;
			seen_word.field_value = result.field_value;
			seen_word.value_valid = result.value_valid;
			seen_word.frame_end = result.frame_end;
			seen_word.frame_status = result.frame_status;
			sb.check_word(seen_word);
		end
	end

	// receiver: switches between always ready, random, periodic and heavy stall
	always @(posedge clk) begin
		recv_cycle <= recv_cycle + 1;
		if (recv_cycle % 300 == 0)
			recv_mode <= $urandom_range(3);
		case (recv_mode)
			0: result.ready <= 1'b1;
			1: result.ready <= $urandom_range(3) != 0;
			2: result.ready <= (recv_cycle % 7) > 2;
			default: result.ready <= $urandom_range(9) == 0;
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (feed.valid && feed.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("FAILURE");
		$finish;
	end

	task automatic send_word(input logic [7:0] b, input logic l);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(3) == 0 ? 0 : $urandom_range(8, 1);
			if (gap != 0) begin
				feed.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(9) == 0 ? $urandom_range(200, 50) : $urandom_range(16, 1);
		end
		burst_left--;
		feed.valid <= 1'b1;
		feed.data_byte <= b;
		feed.last <= l;
		@(posedge clk);
		while (!feed.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i])
			send_word(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	function automatic void push_le(logic [63:0] v, int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			frame_bytes.push_back(v[8*i +: 8]);
	endfunction

	function automatic void build_frame();
		int unsigned slen;
		int unsigned cut;
		logic [31:0] plen;
		frame_bytes.delete();
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(20, 1))
				frame_bytes.push_back(8'($urandom));
			return;
		end
		frame_bytes.push_back($urandom_range(9) != 0 ? sb.cfg.frame_version : 8'($urandom));
		frame_bytes.push_back($urandom_range(7) != 0 ?
			8'($urandom_range(sb.cfg.max_type, 1)) : 8'($urandom));
		frame_bytes.push_back($urandom_range(7) != 0 ?
			8'($urandom_range(sb.cfg.max_status, 0)) : 8'($urandom));
		repeat (3) begin
			case ($urandom_range(9))
				0, 1, 2: slen = 0;
				3: slen = $urandom_range(300, 40);
				default: slen = $urandom_range(6, 1);
			endcase
			push_le(64'(slen), 2);
			repeat (slen)
				frame_bytes.push_back(8'($urandom));
		end
		repeat (CONN_ID_BYTES)
			frame_bytes.push_back(8'($urandom));
		push_le({$urandom, $urandom}, 8);
		push_le(64'($urandom), 4);
		push_le({$urandom, $urandom}, 8);
		case ($urandom_range(9))
			0, 1: plen = 0;
			2: plen = $urandom | 32'h8000_0000;
			3: plen = sb.cfg.max_payload <= 64 ? 32'(sb.cfg.max_payload) : $urandom_range(64, 1);
			4: plen = 32'(sb.cfg.max_payload) + 32'd1;
			5: plen = $urandom | 32'h0200_0000;
			default: plen = $urandom_range(8, 1);
		endcase
		push_le(64'(plen), 4);
		if (!plen[31] && plen <= 32'(sb.cfg.max_payload))
			repeat (plen)
				frame_bytes.push_back(8'($urandom));
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(3, 1))
				frame_bytes.push_back(8'($urandom));
		if ($urandom_range(9) == 0) begin
			cut = $urandom_range(frame_bytes.size() - 1, 1);
			while (frame_bytes.size() > cut)
				void'(frame_bytes.pop_back());
		end
	endfunction

	task automatic wait_drained();
		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input reg_index_t idx, input logic [24:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// upper bits of the narrow registers carry junk that must be dropped
	task automatic write_config(input logic [7:0] ver, input logic [7:0] mt,
			input logic [7:0] ms, input logic [24:0] mp);
		feed.valid <= 1'b0;
		wait_drained();
		put_reg(REG_FRAME_VERSION, {17'($urandom), ver});
		put_reg(REG_MAX_TYPE, {17'($urandom), mt});
		put_reg(REG_MAX_STATUS, {17'($urandom), ms});
		put_reg(REG_MAX_PAYLOAD, mp);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned goal;
		goal = bytes_sent + count;
		while (bytes_sent < goal) begin
			build_frame();
			send_frame();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		feed.valid = 1'b0;
		feed.data_byte = '0;
		feed.last = 1'b0;
		result.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FRAME_VERSION;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short frames at reset settings: each header error, ignored tail, truncation
		frame_bytes = {8'hFF};
		send_frame();
		frame_bytes = {8'h00, 8'hAA};
		send_frame();
		frame_bytes = {8'h01, 8'h00, 8'h00};
		send_frame();
		frame_bytes = {8'h01, 8'h06, 8'h08};
		send_frame();
		frame_bytes = {8'h01, 8'h05, 8'h09};
		send_frame();
		frame_bytes = {8'h01, 8'h05, 8'h08};
		send_frame();
		frame_bytes = {8'h01, 8'h01, 8'h00, 8'h01, 8'h80};
		send_frame();
		frame_bytes = {8'h01, 8'h01};
		send_frame();
		run_random(BYTES_PER_PHASE);

		write_config(8'd0, 8'd255, 8'd255, 25'h1FF_FFFF);
		run_random(BYTES_PER_PHASE);
		write_config(8'd255, 8'd1, 8'd0, 25'd0);
		run_random(BYTES_PER_PHASE);
		write_config(8'($urandom), 8'($urandom_range(255, 1)), 8'($urandom), 25'd5);
		run_random(BYTES_PER_PHASE);
		write_config(8'd1, 8'd5, 8'd8, 25'(PAYLOAD_LIMIT));
		run_random(BYTES_PER_PHASE);

		feed.valid <= 1'b0;
		wait_drained();
		if (sb.mismatch_count == 0 && sb.expected_words.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/rfp_pkg.sv
rtl/core/rfp_feed_if.sv
rtl/core/rfp_result_if.sv
rtl/core/rfp_cfg_regs.sv
rtl/core/rfp_tracker.sv
rtl/core/relay_frame_parser.sv
rtl/core/rfp_checker.sv
verif/relay_frame_parser_test.sv
